// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/pide_pkg.sv =====
package pide_pkg;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] element;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] eigenvalue;
        logic [11:0]        rounds_used;
        logic [1:0]         status;
        logic [3:0]         vector_index;
        logic signed [31:0] vector_element;
        logic               last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_MV_RD,
        S_MV_MUL,
        S_MV_ACC,
        S_RQ_RD,
        S_RQ_M1,
        S_RQ_M2,
        S_RQ_ACC,
        S_RQ_FIN,
        S_MX_RD,
        S_MX_CMP,
        S_ZERO_WR,
        S_SHIFT,
        S_SQ_RD,
        S_SQ_MAG,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT,
        S_DV_RD,
        S_DV_MAG,
        S_DV_RUN,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd1;
    localparam logic [1:0] CFG_ITER_LIMIT  = 2'd2;

    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_LIMIT     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_NORM = 2'd2;

    localparam logic [4:0]  SIZE_RST  = 5'd16;
    localparam logic [24:0] TOL_RST   = 25'd17;
    localparam logic [11:0] LIMIT_RST = 12'd1000;

    localparam logic [48:0] ERR_INIT   = 49'h0_0000_0100_0000;
    localparam logic [63:0] START_ELEM = 64'h0000_0001_0000_0000;
    localparam logic [63:0] MAG_HI     = 64'h0000_0000_1000_0000;
    localparam logic [63:0] MAG_LO     = 64'h0000_0000_0800_0000;

    localparam logic signed [63:0] EIG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] EIG_MIN = -64'sh0000_8000_0000_0000;

endpackage

// ===== rtl/core/power_iteration_dominant_eigen.sv =====
// Dominant eigenvalue by power iteration, Q16.16 matrix in, Q24.24 eigenvalue out.
// Input channel: cmd load writes one matrix element per transfer, one per idle cycle.
// cmd start runs the iteration; o_in_stall stays high until the last result is taken.
// Output channel: n results per start (n = active size), each with the eigenvalue,
// the round count, the status and one Q2.30 vector element; last marks the final one.
// Config channel: index and data, taken only while the block is idle.
// Run order: n writes to seed, one normalize, then per round the matrix-vector
// product and Rayleigh quotient (shared 34x32 multiplier), the shift search, the
// sum of squares, the square root and the divides (one quotient bit per cycle).
// Matrix and vectors live in three one-port-read RAMs (matrix, work and product).
// Reset is synchronous, active low: the block goes idle, the config registers take
// default values, the RAMs keep their contents. A stalled result holds until taken.
module power_iteration_dominant_eigen #(
    parameter int MAX_DIM = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pide_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pide_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [24:0]         i_cfg_data
);
    import pide_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int MAT_D  = MAX_DIM * MAX_DIM;
    localparam int MAT_AW = (MAT_D > 1) ? $clog2(MAT_D) : 1;

    t_state r_state, n_state;

    logic [4:0]  r_size;
    logic [24:0] r_tol;
    logic [11:0] r_limit;

    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [63:0]      r_acc, n_acc;
    logic signed [65:0] r_prod, n_prod;
    logic [29:0]      r_lo, n_lo;
    logic signed [31:0] r_b, n_b;
    logic [63:0]      r_m, n_m;
    logic [5:0]       r_sh_amt, n_sh_amt;
    logic             r_sh_right, n_sh_right;
    logic             r_neg, n_neg;
    logic [27:0]      r_mag, n_mag;
    logic [31:0]      r_nrm, n_nrm;
    logic signed [47:0] r_prev, n_prev;
    logic [48:0]      r_err, n_err;
    logic [11:0]      r_rounds, n_rounds;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_data, n_out_data;

    // ram ports
    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr, mat_raddr;
    logic [31:0]       mat_rdata;
    logic              wv_we;
    logic [IDX_W-1:0]  wv_waddr, wv_raddr;
    logic [31:0]       wv_wdata, wv_rdata;
    logic              pv_we;
    logic [IDX_W-1:0]  pv_waddr, pv_raddr;
    logic [63:0]       pv_wdata, pv_rdata;

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;

    logic        sqrt_start, sqrt_done;
    logic [63:0] sqrt_in;
    logic [31:0] sqrt_root;
    logic        div_start, div_done;
    logic [30:0] div_quot;

    logic        accept, i_last;
    logic [63:0] mag64, scaled64, mv_sum, sq_sum, rq_hi;
    logic signed [63:0] acc_sh, eig_sat;
    logic signed [48:0] eig_diff;
    logic [CNT_W-1:0]   start_n;

    pide_ram #(.WIDTH(32), .DEPTH(MAT_D)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (i_in_data.element),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    pide_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (wv_we),
        .i_waddr (wv_waddr),
        .i_wdata (wv_wdata),
        .i_raddr (wv_raddr),
        .o_rdata (wv_rdata)
    );

    pide_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_prod_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    pide_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sqrt_in),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    pide_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (scaled64[27:0]),
        .i_den   (r_nrm),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        if (r_size == 5'd0) begin
            start_n = CNT_W'(1);
        end else if (32'(r_size) > MAX_DIM) begin
            start_n = CNT_W'(MAX_DIM);
        end else begin
            start_n = CNT_W'(r_size);
        end
    end

    // magnitude of the product element being read, then the common scale
    assign mag64    = pv_rdata[63] ? (64'd0 - pv_rdata) : pv_rdata;
    assign scaled64 = r_sh_right ? (mag64 >> r_sh_amt) : (mag64 << r_sh_amt);
    assign i_last   = ((r_i + 1'b1) == r_n);
    assign mv_sum   = r_acc + 64'($signed(r_prod[63:0]) >>> 14);
    assign sq_sum   = r_acc + r_prod[63:0];
    assign rq_hi    = 64'($signed(pv_rdata) >>> 30);
    assign acc_sh   = $signed(r_acc) >>> 8;
    assign sqrt_in  = sq_sum;
    assign n_prod   = 66'(mul_a) * 66'(mul_b);

    always_comb begin
        if (acc_sh > EIG_MAX) begin
            eig_sat = EIG_MAX;
        end else if (acc_sh < EIG_MIN) begin
            eig_sat = EIG_MIN;
        end else begin
            eig_sat = acc_sh;
        end
        eig_diff = 49'($signed(eig_sat[47:0])) - 49'(r_prev);
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_acc       = r_acc;
        n_lo        = r_lo;
        n_b         = r_b;
        n_m         = r_m;
        n_sh_amt    = r_sh_amt;
        n_sh_right  = r_sh_right;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_nrm       = r_nrm;
        n_prev      = r_prev;
        n_err       = r_err;
        n_rounds    = r_rounds;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        mat_we    = 1'b0;
        mat_waddr = MAT_AW'(32'(i_in_data.row_index) * MAX_DIM + 32'(i_in_data.col_index));
        mat_raddr = MAT_AW'(32'(r_i) * MAX_DIM + 32'(r_j));
        wv_we     = 1'b0;
        wv_waddr  = r_i[IDX_W-1:0];
        wv_wdata  = '0;
        wv_raddr  = r_i[IDX_W-1:0];
        pv_we     = 1'b0;
        pv_waddr  = r_i[IDX_W-1:0];
        pv_wdata  = START_ELEM;
        pv_raddr  = r_i[IDX_W-1:0];
        mul_a     = 34'($signed(mat_rdata));
        mul_b     = $signed(wv_rdata);
        sqrt_start = 1'b0;
        div_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.cmd == CMD_LOAD) begin
                        mat_we = (32'(i_in_data.row_index) < MAX_DIM)
                              && (32'(i_in_data.col_index) < MAX_DIM);
                    end else begin
                        n_n      = start_n;
                        n_i      = '0;
                        n_prev   = '0;
                        n_rounds = '0;
                        n_err    = ERR_INIT;
                        n_state  = S_INIT;
                    end
                end
            end
            S_INIT: begin
                pv_we = 1'b1;
                n_i   = r_i + 1'b1;
                if (i_last) begin
                    n_i     = '0;
                    n_m     = '0;
                    n_state = S_MX_RD;
                end
            end
            S_CHECK: begin
                if ((r_err > {24'd0, r_tol}) && (r_rounds < r_limit)) begin
                    n_rounds = r_rounds + 12'd1;
                    n_i      = '0;
                    n_j      = '0;
                    n_acc    = '0;
                    n_state  = S_MV_RD;
                end else begin
                    n_status = (r_err <= {24'd0, r_tol}) ? STATUS_CONVERGED : STATUS_LIMIT;
                    n_i      = '0;
                    n_state  = S_OUT_RD;
                end
            end
            S_MV_RD: begin
                wv_raddr = r_j[IDX_W-1:0];
                n_state  = S_MV_MUL;
            end
            S_MV_MUL: begin
                n_state = S_MV_ACC;
            end
            S_MV_ACC: begin
                n_acc   = mv_sum;
                n_j     = r_j + 1'b1;
                n_state = S_MV_RD;
                if ((r_j + 1'b1) == r_n) begin
                    pv_we    = 1'b1;
                    pv_wdata = mv_sum;
                    n_acc    = '0;
                    n_j      = '0;
                    n_i      = r_i + 1'b1;
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_RQ_RD;
                    end
                end
            end
            S_RQ_RD: begin
                n_state = S_RQ_M1;
            end
            S_RQ_M1: begin
                // x = hi * 2^30 + lo, so x*b / 2^30 = hi*b + lo*b / 2^30
                mul_a   = $signed(rq_hi[33:0]);
                n_lo    = pv_rdata[29:0];
                n_b     = $signed(wv_rdata);
                n_state = S_RQ_M2;
            end
            S_RQ_M2: begin
                n_acc   = r_acc + r_prod[63:0];
                mul_a   = $signed({4'd0, r_lo});
                mul_b   = r_b;
                n_state = S_RQ_ACC;
            end
            S_RQ_ACC: begin
                n_acc   = r_acc + 64'($signed(r_prod[63:0]) >>> 30);
                n_i     = r_i + 1'b1;
                n_state = i_last ? S_RQ_FIN : S_RQ_RD;
            end
            S_RQ_FIN: begin
                n_prev  = eig_sat[47:0];
                n_err   = eig_diff[48] ? 49'(-eig_diff) : 49'(eig_diff);
                n_i     = '0;
                n_m     = '0;
                n_state = S_MX_RD;
            end
            S_MX_RD: begin
                n_state = S_MX_CMP;
            end
            S_MX_CMP: begin
                if (mag64 > r_m) begin
                    n_m = mag64;
                end
                n_i     = r_i + 1'b1;
                n_state = S_MX_RD;
                if (i_last) begin
                    n_i        = '0;
                    n_sh_amt   = '0;
                    n_sh_right = 1'b0;
                    n_state    = (n_m == 64'd0) ? S_ZERO_WR : S_SHIFT;
                end
            end
            S_ZERO_WR: begin
                wv_we = 1'b1;
                n_i   = r_i + 1'b1;
                if (i_last) begin
                    n_i      = '0;
                    n_status = STATUS_ZERO_NORM;
                    n_state  = S_OUT_RD;
                end
            end
            S_SHIFT: begin
                // bring the largest magnitude into [2^27, 2^28)
                if (r_m >= MAG_HI) begin
                    n_m        = r_m >> 1;
                    n_sh_amt   = r_sh_amt + 6'd1;
                    n_sh_right = 1'b1;
                end else if (r_m < MAG_LO) begin
                    n_m        = r_m << 1;
                    n_sh_amt   = r_sh_amt + 6'd1;
                    n_sh_right = 1'b0;
                end else begin
                    n_i     = '0;
                    n_acc   = '0;
                    n_state = S_SQ_RD;
                end
            end
            S_SQ_RD: begin
                n_state = S_SQ_MAG;
            end
            S_SQ_MAG: begin
                n_mag   = scaled64[27:0];
                n_state = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                mul_a   = $signed({6'd0, r_mag});
                mul_b   = $signed({4'd0, r_mag});
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                n_acc   = sq_sum;
                n_i     = r_i + 1'b1;
                n_state = S_SQ_RD;
                if (i_last) begin
                    sqrt_start = 1'b1;
                    n_i        = '0;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    n_nrm   = sqrt_root;
                    n_state = S_DV_RD;
                end
            end
            S_DV_RD: begin
                n_state = S_DV_MAG;
            end
            S_DV_MAG: begin
                div_start = 1'b1;
                n_neg     = pv_rdata[63];
                n_state   = S_DV_RUN;
            end
            S_DV_RUN: begin
                if (div_done) begin
                    wv_we    = 1'b1;
                    wv_wdata = r_neg ? (32'd0 - {1'b0, div_quot}) : {1'b0, div_quot};
                    n_i      = r_i + 1'b1;
                    n_state  = i_last ? S_CHECK : S_DV_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out_data.eigenvalue     = r_prev;
                n_out_data.rounds_used    = r_rounds;
                n_out_data.status         = r_status;
                n_out_data.vector_index   = 4'(r_i);
                n_out_data.vector_element = $signed(wv_rdata);
                n_out_data.last           = i_last;
                n_out_valid               = 1'b1;
                n_state                   = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_i         = r_i + 1'b1;
                    n_state     = i_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_RST;
            r_tol       <= TOL_RST;
            r_limit     <= LIMIT_RST;
            r_prev      <= '0;
            r_rounds    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_rounds    <= n_rounds;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MATRIX_SIZE: r_size  <= i_cfg_data[4:0];
                    CFG_TOLERANCE:   r_tol   <= i_cfg_data;
                    CFG_ITER_LIMIT:  r_limit <= i_cfg_data[11:0];
                    default:         ;
                endcase
            end
        end
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_lo       <= n_lo;
        r_b        <= n_b;
        r_m        <= n_m;
        r_sh_amt   <= n_sh_amt;
        r_sh_right <= n_sh_right;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_nrm      <= n_nrm;
        r_err      <= n_err;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    `ASSERT_SYNC(a_rounds_bound, (r_state == S_CHECK) |-> (r_rounds <= r_limit), "round count above limit")
    `ASSERT_SYNC(a_out_state, o_out_valid |-> (r_state == S_OUT_HOLD), "result shown outside output state")
    `ASSERT_SYNC(a_start_runs, (accept && (i_in_data.cmd == CMD_START)) |=> (r_state == S_INIT), "start not taken")
    `ASSERT_SYNC(a_sqrt_wait, sqrt_done |-> (r_state == S_SQRT), "root finished while not waiting")
    `ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")
endmodule

// ===== rtl/core/pide_ram.sv =====
module pide_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/pide_isqrt.sv =====
module pide_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] r_x, n_x;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;
    logic [63:0] trial;

    // one result bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_x    = r_x;
        n_res  = r_res;
        n_bit  = r_bit;
        trial  = r_res + r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_x    = i_radicand;
            n_res  = '0;
            n_bit  = 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_x >= trial) begin
                n_x   = r_x - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit == 64'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

// ===== rtl/core/pide_div.sv =====
module pide_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [27:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quot
);
    // quotient of num * 2^30 / den, num never above den
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_first, n_first;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [30:0] r_quot, n_quot;
    logic [32:0] shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_first = r_first;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;
        shifted = r_first ? r_rem : {r_rem[31:0], 1'b0};
        if (i_start) begin
            n_busy  = 1'b1;
            n_first = 1'b1;
            n_cnt   = '0;
            n_rem   = {5'd0, i_num};
            n_den   = i_den;
            n_quot  = '0;
        end else if (r_busy) begin
            n_first = 1'b0;
            if (shifted >= {1'b0, r_den}) begin
                n_rem  = shifted - {1'b0, r_den};
                n_quot = {r_quot[29:0], 1'b1};
            end else begin
                n_rem  = shifted;
                n_quot = {r_quot[29:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd30) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_first <= n_first;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quot  <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== tb/power_iteration_dominant_eigen_tb.sv =====
`timescale 1ns / 100ps

module power_iteration_dominant_eigen_tb;
    import pide_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [24:0] i_cfg_data = '0;

    power_iteration_dominant_eigen dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block: matrix, vectors and registers
    logic signed [31:0] mat_q [16][16];
    bit                 mat_loaded [16][16];
    int                 vec_q [16];
    longint             prod_q [16];
    logic [4:0]         size_reg = SIZE_RST;
    logic [24:0]        tol_reg = TOL_RST;
    logic [11:0]        limit_reg = LIMIT_RST;

    t_out_item pending_results [$];
    int        mismatches = 0;
    bit        fast = 1'b0;
    int        hold_req = 0;
    int        hold_ack = 0;
    int        stall_left = 0;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale magnitudes into [2^27, 2^28), divide by the root of the sum of squares
    function automatic bit normalize_vec(int n);
        longint unsigned mag [16];
        longint unsigned m, sum, nrm, q;
        int r, l;
        m = 0;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            mag[i] = prod_q[i] < 0 ? longint'(-prod_q[i]) : prod_q[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < n; i++) vec_q[i] = 0;
            return 1'b0;
        end
        r = 0;
        l = 0;
        while ((m >> r) >= (64'd1 << 28)) r++;
        while ((m << l) < (64'd1 << 27)) l++;
        for (int i = 0; i < n; i++) begin
            mag[i] = (mag[i] >> r) << l;
            sum += mag[i] * mag[i];
        end
        nrm = isqrt(sum);
        for (int i = 0; i < n; i++) begin
            q = (mag[i] << 30) / nrm;
            vec_q[i] = prod_q[i] < 0 ? -int'(q) : int'(q);
        end
        return 1'b1;
    endfunction

    function automatic void predict_eigen_run();
        int        n, rounds;
        logic [1:0] st;
        longint    err, prev, acc, val, s, x, b, hi, lo;
        t_out_item res;
        n = size_reg == 0 ? 1 : (size_reg > 16 ? 16 : int'(size_reg));
        for (int i = 0; i < n; i++) prod_q[i] = longint'(START_ELEM);
        void'(normalize_vec(n));
        prev = 0;
        rounds = 0;
        st = STATUS_CONVERGED;
        err = 64'd1 << 24;
        while (err > longint'(tol_reg) && rounds < int'(limit_reg)) begin
            rounds++;
            for (int i = 0; i < n; i++) begin
                s = 0;
                for (int j = 0; j < n; j++)
                    s += (longint'(mat_q[i][j]) * longint'(vec_q[j])) >>> 14;
                prod_q[i] = s;
            end
            acc = 0;
            for (int i = 0; i < n; i++) begin
                x = prod_q[i];
                b = vec_q[i];
                hi = x >>> 30;
                lo = x - (hi <<< 30);
                acc += hi * b + ((lo * b) >>> 30);
            end
            val = acc >>> 8;
            if (val > EIG_MAX) val = EIG_MAX;
            if (val < EIG_MIN) val = EIG_MIN;
            err = val - prev;
            if (err < 0) err = -err;
            prev = val;
            if (!normalize_vec(n)) begin
                st = STATUS_ZERO_NORM;
                break;
            end
        end
        if (st != STATUS_ZERO_NORM)
            st = err <= longint'(tol_reg) ? STATUS_CONVERGED : STATUS_LIMIT;
        for (int i = 0; i < n; i++) begin
            res.eigenvalue     = prev[47:0];
            res.rounds_used    = rounds[11:0];
            res.status         = st;
            res.vector_index   = i[3:0];
            res.vector_element = vec_q[i];
            res.last           = (i == n - 1);
            pending_results.push_back(res);
        end
    endfunction

    function automatic void track_item(t_in_item it);
        if (it.cmd == CMD_LOAD) begin
            mat_q[it.row_index][it.col_index] = it.element;
            mat_loaded[it.row_index][it.col_index] = 1'b1;
        end else begin
            predict_eigen_run();
        end
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report("unexpected result, index", got.vector_index, -1);
        end else begin
            want = pending_results.pop_front();
            if (got.eigenvalue != want.eigenvalue)
                report("eigenvalue", got.eigenvalue, want.eigenvalue);
            if (got.rounds_used != want.rounds_used)
                report("rounds_used", got.rounds_used, want.rounds_used);
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.vector_index != want.vector_index)
                report("vector_index", got.vector_index, want.vector_index);
            if (got.vector_element != want.vector_element)
                report("vector_element", got.vector_element, want.vector_element);
            if (got.last != want.last)
                report("last", got.last, want.last);
        end
    endtask

    // result side: random stall per transfer, plus one long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result(o_out_data);
            stall_left = fast ? 0 : $urandom_range(0, 10);
        end
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            stall_left = 400;
        end
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_res);
        int gap;
        gap = fast ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) pending_results.push_back(typed_res);
        else track_item(it);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [24:0] val);
        drain_results();
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MATRIX_SIZE: size_reg = val[4:0];
            CFG_TOLERANCE:   tol_reg = val;
            CFG_ITER_LIMIT:  limit_reg = val[11:0];
            default: ;
        endcase
    endtask

    function automatic t_in_item mk_item(logic cmd, int r, int c, logic [31:0] e);
        t_in_item it;
        it.cmd       = cmd;
        it.row_index = r[3:0];
        it.col_index = c[3:0];
        it.element   = e;
        return it;
    endfunction

    function automatic logic [31:0] rand_element();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h3_0000)) - 32'h1_8000;
            2: return 32'($urandom_range(0, 32'h300)) - 32'h180;
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [24:0] val;
        t_in_item    it;
        bit          typed;
        t_out_item   res;
    } t_dir_row;

    t_dir_row dir_rows [$];

    function automatic t_dir_row cfg_row(logic [1:0] idx, logic [24:0] val);
        t_dir_row d;
        d = '{default: '0};
        d.is_cfg = 1'b1;
        d.idx = idx;
        d.val = val;
        return d;
    endfunction

    function automatic t_dir_row item_row(logic cmd, int r, int c, logic [31:0] e);
        t_dir_row d;
        d = '{default: '0};
        d.it = mk_item(cmd, r, c, e);
        return d;
    endfunction

    // single-element run whose result is obvious
    function automatic t_dir_row known_start(int rounds, logic [1:0] st, logic [31:0] v);
        t_dir_row d;
        d = item_row(CMD_START, 0, 0, 0);
        d.typed = 1'b1;
        d.res.eigenvalue     = '0;
        d.res.rounds_used    = rounds[11:0];
        d.res.status         = st;
        d.res.vector_index   = '0;
        d.res.vector_element = v;
        d.res.last           = 1'b1;
        return d;
    endfunction

    initial begin
        #50_000_000;
        $display("power_iteration_dominant_eigen: mismatch");
        $finish;
    end

    initial begin
        int rand_items, phase, n, sz, lim, tol, starts;
        t_out_item none;
        none = '0;
        rand_items = 0;
        phase = 0;
        foreach (mat_loaded[r, c]) mat_loaded[r][c] = 1'b0;
        foreach (mat_q[r, c]) mat_q[r][c] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no round at all, then zero norm, then extremes of elements and sizes
        dir_rows.push_back(cfg_row(CFG_MATRIX_SIZE, 1));
        dir_rows.push_back(cfg_row(CFG_TOLERANCE, 25'd16777216));
        dir_rows.push_back(cfg_row(CFG_ITER_LIMIT, 1));
        dir_rows.push_back(item_row(CMD_LOAD, 0, 0, 32'h7fff_ffff));
        dir_rows.push_back(known_start(0, STATUS_CONVERGED, 32'h4000_0000));
        dir_rows.push_back(cfg_row(CFG_TOLERANCE, 0));
        dir_rows.push_back(cfg_row(CFG_ITER_LIMIT, 5));
        dir_rows.push_back(item_row(CMD_LOAD, 0, 0, 32'h0));
        dir_rows.push_back(known_start(1, STATUS_ZERO_NORM, 32'h0));
        dir_rows.push_back(item_row(CMD_LOAD, 15, 15, 32'h8000_0000));
        dir_rows.push_back(item_row(CMD_LOAD, 0, 15, 32'h7fff_ffff));
        dir_rows.push_back(item_row(CMD_LOAD, 15, 0, 32'h1));
        dir_rows.push_back(item_row(CMD_LOAD, 0, 0, 32'h8000_0000));
        dir_rows.push_back(item_row(CMD_START, 0, 0, 0));
        dir_rows.push_back(cfg_row(CFG_ITER_LIMIT, 4095));
        dir_rows.push_back(item_row(CMD_LOAD, 0, 0, 32'h0001_0000));
        dir_rows.push_back(item_row(CMD_START, 0, 0, 0));
        dir_rows.push_back(cfg_row(CFG_MATRIX_SIZE, 0));
        dir_rows.push_back(item_row(CMD_START, 0, 0, 0));
        dir_rows.push_back(cfg_row(CFG_MATRIX_SIZE, 2));
        dir_rows.push_back(cfg_row(CFG_TOLERANCE, 25'hff_ffff));
        dir_rows.push_back(cfg_row(CFG_ITER_LIMIT, 3));
        dir_rows.push_back(item_row(CMD_LOAD, 0, 1, 32'hffff_0000));
        dir_rows.push_back(item_row(CMD_LOAD, 1, 0, 32'h0002_8000));
        dir_rows.push_back(item_row(CMD_LOAD, 1, 1, 32'h0000_c000));
        dir_rows.push_back(item_row(CMD_START, 0, 0, 0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) write_cfg(dir_rows[k].idx, dir_rows[k].val);
            else send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
        end

        while (rand_items < 130) begin
            phase++;
            if (phase == 1) begin
                sz = 31;
            end else begin
                case ($urandom_range(0, 9))
                    0: sz = 0;
                    1: sz = 16;
                    default: sz = $urandom_range(1, 4);
                endcase
            end
            n = sz == 0 ? 1 : (sz > 16 ? 16 : sz);
            if (n > 4) lim = $urandom_range(1, 2);
            else if (n == 1 && $urandom_range(0, 3) == 0) lim = 4095;
            else lim = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0: tol = 0;
                1: tol = 17;
                2: tol = $urandom_range(0, 1 << 20);
                default: tol = 16777216;
            endcase
            write_cfg(CFG_MATRIX_SIZE, 25'(sz));
            write_cfg(CFG_TOLERANCE, 25'(tol));
            write_cfg(CFG_ITER_LIMIT, 25'(lim));
            fast = ($urandom_range(0, 3) == 0);
            starts = $urandom_range(1, 3);
            repeat (starts) begin
                repeat ($urandom_range(0, 6)) begin
                    send_item(mk_item(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                                      rand_element()), 1'b0, none);
                    rand_items++;
                end
                // every active entry must hold a value before a start
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        if (!mat_loaded[r][c])
                            send_item(mk_item(CMD_LOAD, r, c, rand_element()), 1'b0, none);
                if (phase == 2) drain_results();
                if (phase == 1) hold_req++;
                send_item(mk_item(CMD_START, $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom), 1'b0, none);
                rand_items++;
                if (phase == 1) begin
                    // these wait behind the run while results are held back
                    repeat (4) begin
                        send_item(mk_item(CMD_LOAD, $urandom_range(0, 15),
                                          $urandom_range(0, 15), rand_element()), 1'b0, none);
                        rand_items++;
                    end
                end
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("power_iteration_dominant_eigen: match");
        end else begin
            $display("power_iteration_dominant_eigen: mismatch");
        end
        $finish;
    end

endmodule
